// File: rtl/core/lsli_pkg.sv
package lsli_pkg;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_line;
  } req_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               singular;
  } res_t;

  localparam int unsigned DivBits  = 144;
  localparam int unsigned LineBits = 64;
  localparam logic [63:0] QuoCap   = 64'h0000_0100_0000_0000;
  localparam logic [63:0] AccMax   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] AccMin   = 64'h8000_0000_0000_0000;

endpackage

// File: rtl/core/least_squares_line_intersection.sv
// Each line forms direction and position products, then five divisions (load, 64 steps,
// accumulate); a zero-length line stops after its direction products.
// The line that ends a level adds six 128-bit products on the shared
// 34x34 multiplier, a check state, two divisions of DivBits steps and the result state.
// One request at a time; busy_o stays high until the work of the request is done.
// done_o pulses for one cycle with the result; the receiver cannot stall it.
// Reset clears the accumulators and the level state; operand registers are not reset.
module least_squares_line_intersection
  import lsli_pkg::*;
#(
  parameter int unsigned MAX_LINES = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output res_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_LINES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_DLOAD, S_DRUN, S_DAPP,
    S_SVMUL, S_SVCHK, S_SDLOAD, S_SDFIN, S_OUT
  } state_e;

  state_e state_q;
  logic [2:0] k_q, j_q, p_q;
  logic       xy_q, sdiv_q;
  logic [CntW-1:0] cnt_q;
  logic at_first_q, bad_q, last_q, sing_q;
  logic signed [15:0] dx_q, dy_q, dz_q;
  logic signed [31:0] px_q, py_q, fz_q, ptx_q, pty_q;
  logic [31:0] sxx_q, syy_q, szz_q;
  logic signed [31:0] sxy_q;
  logic [63:0] t_q, nac_q, nbc_q;
  logic [63:0] aa_q, bb_q, ab_q, ac_q, bc_q;
  logic signed [67:0] mul_q;
  logic [127:0] pacc_q, ptmp_q, den_q, nx_q, ny_q;
  logic [128:0] rem_q;
  logic [127:0] dv_q;
  logic [143:0] sh_q;
  logic [63:0] q_q;
  logic [7:0]  dcnt_q;
  logic        dsat_q, nsgn_q;

  logic [31:0] l2;
  logic signed [33:0] opa, opb;
  logic [63:0] sa, sb, ma, mb, lnum, lmag, qv;
  logic pneg;
  logic [128:0] rem_sh;
  logic ge;
  logic [63:0] q_n;
  logic [127:0] pp_sh, nsel, nmag, dmag;
  logic [63:0] qr;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? AccMin : AccMax;
    end
    return s;
  endfunction

  function automatic logic [31:0] to_q32(input logic [63:0] q, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(0 - q[31:0]);
    end else begin
      r = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    return r;
  endfunction

  assign l2 = sxx_q + syy_q + szz_q;

  always_comb begin
    unique case (p_q)
      3'd0:    begin sa = ab_q; sb = ab_q; end
      3'd1:    begin sa = aa_q; sb = bb_q; end
      3'd2:    begin sa = bb_q; sb = ac_q; end
      3'd3:    begin sa = ab_q; sb = bc_q; end
      3'd4:    begin sa = aa_q; sb = bc_q; end
      default: begin sa = ab_q; sb = ac_q; end
    endcase
    ma   = sa[63] ? 64'(0 - sa) : sa;
    mb   = sb[63] ? 64'(0 - sb) : sb;
    pneg = sa[63] ^ sb[63];
  end

  always_comb begin
    opa = '0;
    opb = '0;
    if (state_q == S_MUL1) begin
      case (k_q)
        3'd0:    begin opa = 34'(dx_q); opb = 34'(dx_q); end
        3'd1:    begin opa = 34'(dy_q); opb = 34'(dy_q); end
        3'd2:    begin opa = 34'(dz_q); opb = 34'(dz_q); end
        default: begin opa = 34'(dx_q); opb = 34'(dy_q); end
      endcase
    end else if (state_q == S_MUL2) begin
      case (k_q)
        3'd0:    begin opa = {2'b0, syy_q}; opb = 34'(px_q); end
        3'd1:    begin opa = 34'(sxy_q);    opb = 34'(py_q); end
        3'd2:    begin opa = 34'(sxy_q);    opb = 34'(px_q); end
        default: begin opa = {2'b0, sxx_q}; opb = 34'(py_q); end
      endcase
    end else begin
      case (k_q)
        3'd0:    begin opa = {2'b0, ma[31:0]};  opb = {2'b0, mb[31:0]};  end
        3'd1:    begin opa = {2'b0, ma[31:0]};  opb = {2'b0, mb[63:32]}; end
        3'd2:    begin opa = {2'b0, ma[63:32]}; opb = {2'b0, mb[31:0]};  end
        default: begin opa = {2'b0, ma[63:32]}; opb = {2'b0, mb[63:32]}; end
      endcase
    end
  end

  always_comb begin
    case (k_q)
      3'd1:    pp_sh = {64'b0, mul_q[63:0]};
      3'd4:    pp_sh = {mul_q[63:0], 64'b0};
      default: pp_sh = {32'b0, mul_q[63:0], 32'b0};
    endcase
  end

  always_comb begin
    case (j_q)
      3'd0:    lnum = {16'b0, syy_q, 16'b0};
      3'd1:    lnum = {16'b0, sxx_q, 16'b0};
      3'd2:    lnum = {{16{sxy_q[31]}}, sxy_q, 16'b0};
      3'd3:    lnum = nac_q;
      default: lnum = nbc_q;
    endcase
    lmag = lnum[63] ? 64'(0 - lnum) : lnum;
    qv   = (nsgn_q ^ (j_q == 3'd2 || j_q == 3'd3)) ? 64'(0 - q_q) : q_q;
  end

  always_comb begin
    nsel = xy_q ? ny_q : nx_q;
    nmag = nsel[127] ? 128'(0 - nsel) : nsel;
    dmag = den_q[127] ? 128'(0 - den_q) : den_q;
    rem_sh = {rem_q[127:0], sh_q[143]};
    ge  = rem_sh >= {1'b0, dv_q};
    q_n = {q_q[62:0], ge};
    if (dsat_q && q_n > QuoCap) begin
      q_n = QuoCap;
    end
    qr = q_q;
    if ({rem_q, 1'b0} >= {2'b0, dv_q} && q_q < QuoCap) begin
      qr = q_q + 64'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      k_q        <= '0;
      j_q        <= '0;
      p_q        <= '0;
      xy_q       <= 1'b0;
      sdiv_q     <= 1'b0;
      cnt_q      <= '0;
      at_first_q <= 1'b1;
      bad_q      <= 1'b0;
      fz_q       <= '0;
      aa_q       <= '0;
      bb_q       <= '0;
      ab_q       <= '0;
      ac_q       <= '0;
      bc_q       <= '0;
    end else begin
      mul_q <= opa * opb;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            dx_q   <= req_i.dir_x;
            dy_q   <= req_i.dir_y;
            dz_q   <= req_i.dir_z;
            px_q   <= req_i.pos_x;
            py_q   <= req_i.pos_y;
            last_q <= req_i.last_line;
            k_q    <= '0;
            p_q    <= '0;
            if (at_first_q) begin
              fz_q       <= req_i.pos_z;
              at_first_q <= 1'b0;
            end
            if (cnt_q < CntW'(MAX_LINES)) begin
              cnt_q   <= cnt_q + CntW'(1);
              state_q <= S_MUL1;
            end else if (req_i.last_line) begin
              state_q <= S_SVMUL;
            end
          end
        end
        S_MUL1: begin
          case (k_q)
            3'd1:    sxx_q <= mul_q[31:0];
            3'd2:    syy_q <= mul_q[31:0];
            3'd3:    szz_q <= mul_q[31:0];
            3'd4:    sxy_q <= mul_q[31:0];
            default: ;
          endcase
          k_q <= k_q + 3'd1;
          if (k_q == 3'd4) begin
            k_q <= '0;
            if (l2 == '0) begin
              bad_q   <= 1'b1;
              state_q <= last_q ? S_SVMUL : S_IDLE;
            end else begin
              state_q <= S_MUL2;
            end
          end
        end
        S_MUL2: begin
          case (k_q)
            3'd1:    t_q   <= mul_q[63:0];
            3'd2:    nac_q <= t_q - mul_q[63:0];
            3'd3:    t_q   <= mul_q[63:0];
            3'd4:    nbc_q <= t_q - mul_q[63:0];
            default: ;
          endcase
          k_q <= k_q + 3'd1;
          if (k_q == 3'd4) begin
            k_q     <= '0;
            j_q     <= '0;
            state_q <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          nsgn_q  <= lnum[63];
          sh_q    <= {lmag + {33'b0, l2[31:1]}, 80'b0};
          dv_q    <= {96'b0, l2};
          rem_q   <= '0;
          q_q     <= '0;
          dcnt_q  <= 8'(LineBits);
          dsat_q  <= 1'b0;
          sdiv_q  <= 1'b0;
          state_q <= S_DRUN;
        end
        S_DRUN: begin
          rem_q  <= ge ? rem_sh - {1'b0, dv_q} : rem_sh;
          sh_q   <= {sh_q[142:0], 1'b0};
          q_q    <= q_n;
          dcnt_q <= dcnt_q - 8'd1;
          if (dcnt_q == 8'd1) begin
            state_q <= sdiv_q ? S_SDFIN : S_DAPP;
          end
        end
        S_DAPP: begin
          case (j_q)
            3'd0:    aa_q <= sat_add(aa_q, qv);
            3'd1:    bb_q <= sat_add(bb_q, qv);
            3'd2:    ab_q <= sat_add(ab_q, qv);
            3'd3:    ac_q <= sat_add(ac_q, qv);
            default: bc_q <= sat_add(bc_q, qv);
          endcase
          if (j_q == 3'd4) begin
            state_q <= last_q ? S_SVMUL : S_IDLE;
          end else begin
            j_q     <= j_q + 3'd1;
            state_q <= S_DLOAD;
          end
        end
        S_SVMUL: begin
          if (k_q == 3'd0) begin
            pacc_q <= '0;
          end else if (k_q != 3'd5) begin
            pacc_q <= pacc_q + pp_sh;
          end
          k_q <= k_q + 3'd1;
          if (k_q == 3'd5) begin
            k_q <= '0;
            if (!p_q[0]) begin
              ptmp_q <= pneg ? 128'(0 - pacc_q) : pacc_q;
            end else begin
              case (p_q)
                3'd1:    den_q <= pneg ? ptmp_q + pacc_q : ptmp_q - pacc_q;
                3'd3:    nx_q  <= pneg ? ptmp_q + pacc_q : ptmp_q - pacc_q;
                default: ny_q  <= pneg ? ptmp_q + pacc_q : ptmp_q - pacc_q;
              endcase
            end
            if (p_q == 3'd5) begin
              state_q <= S_SVCHK;
            end else begin
              p_q <= p_q + 3'd1;
            end
          end
        end
        S_SVCHK: begin
          sing_q <= bad_q || den_q == '0;
          ptx_q  <= '0;
          pty_q  <= '0;
          xy_q   <= 1'b0;
          state_q <= (bad_q || den_q == '0) ? S_OUT : S_SDLOAD;
        end
        S_SDLOAD: begin
          nsgn_q  <= nsel[127] ^ den_q[127];
          sh_q    <= {nmag, 16'b0};
          dv_q    <= dmag;
          rem_q   <= '0;
          q_q     <= '0;
          dcnt_q  <= 8'(DivBits);
          dsat_q  <= 1'b1;
          sdiv_q  <= 1'b1;
          state_q <= S_DRUN;
        end
        S_SDFIN: begin
          if (xy_q) begin
            pty_q   <= to_q32(qr, nsgn_q);
            state_q <= S_OUT;
          end else begin
            ptx_q   <= to_q32(qr, nsgn_q);
            xy_q    <= 1'b1;
            state_q <= S_SDLOAD;
          end
        end
        S_OUT: begin
          aa_q       <= '0;
          bb_q       <= '0;
          ab_q       <= '0;
          ac_q       <= '0;
          bc_q       <= '0;
          fz_q       <= '0;
          at_first_q <= 1'b1;
          bad_q      <= 1'b0;
          cnt_q      <= '0;
          state_q    <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o         = state_q != S_IDLE;
  assign done_o         = state_q == S_OUT;
  assign res_o.point_x  = ptx_q;
  assign res_o.point_y  = pty_q;
  assign res_o.point_z  = fz_q;
  assign res_o.singular = sing_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("no return to idle after result");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (cnt_q < CntW'(MAX_LINES) || req_i.last_line) |=> busy_o)
    else $error("request not taken");
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.singular |-> res_o.point_x == 0 && res_o.point_y == 0)
    else $error("singular result with nonzero point");
`endif

endmodule

// File: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lsli_pkg::*;

  localparam int unsigned MaxLines = 64;
  localparam int unsigned NumRandom = 450;

  typedef struct {
    req_t req;
    bit   typed;
    res_t res;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  res_t res_o;

  logic typed_q;
  res_t typed_res_q;

  res_t point_q[$];
  int   errors;

  longint sum_aa, sum_bb, sum_ab, sum_ac, sum_bc;
  logic signed [31:0] first_z;
  bit at_first_line, bad_dir_seen;
  int unsigned lines_in_level;

  least_squares_line_intersection #(
    .MAX_LINES(MaxLines)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAIL least_squares_line_intersection");
    $finish;
  end

  function automatic longint round_div(longint n, longint unsigned d);
    longint unsigned mag, r;
    mag = n < 0 ? -n : n;
    r = (mag + d / 2) / d;
    return n < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(signed'(AccMax))) return AccMax;
    if (s < 65'(signed'(AccMin))) return AccMin;
    return longint'(s);
  endfunction

  function automatic logic [127:0] wide_mul(longint a, longint b);
    logic [127:0] x, y;
    x = {{64{a[63]}}, a};
    y = {{64{b[63]}}, b};
    return x * y;
  endfunction

  function automatic logic signed [31:0] coord_div(logic [127:0] num, logic [127:0] den);
    logic nn, dn;
    logic [127:0] n, d;
    logic [143:0] scaled, q, rem;
    logic [63:0] qc;
    nn = num[127];
    dn = den[127];
    n = nn ? -num : num;
    d = dn ? -den : den;
    scaled = {n, 16'b0};
    q = scaled / {16'b0, d};
    rem = scaled % {16'b0, d};
    qc = (q > 144'(QuoCap)) ? QuoCap : q[63:0];
    if ({rem, 1'b0} >= {17'b0, d} && qc < QuoCap) qc++;
    if (nn != dn) return (qc >= 64'h8000_0000) ? 32'sh8000_0000 : -qc[31:0];
    return (qc > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : qc[31:0];
  endfunction

  function automatic void clear_level();
    sum_aa = 0; sum_bb = 0; sum_ab = 0; sum_ac = 0; sum_bc = 0;
    first_z = '0;
    at_first_line = 1'b1;
    bad_dir_seen = 1'b0;
    lines_in_level = 0;
  endfunction

  function automatic bit add_line(req_t r, output res_t pt);
    longint dx, dy, dz, px, py;
    longint unsigned l2;
    logic [127:0] den, nx, ny;
    dx = longint'(r.dir_x); dy = longint'(r.dir_y); dz = longint'(r.dir_z);
    px = longint'(r.pos_x); py = longint'(r.pos_y);
    l2 = dx * dx + dy * dy + dz * dz;
    if (at_first_line) begin
      first_z = r.pos_z;
      at_first_line = 1'b0;
    end
    if (lines_in_level < MaxLines) begin
      lines_in_level++;
      if (l2 == 0) begin
        bad_dir_seen = 1'b1;
      end else begin
        sum_aa = sat_sum(sum_aa, round_div(dy * dy * 65536, l2));
        sum_bb = sat_sum(sum_bb, round_div(dx * dx * 65536, l2));
        sum_ab = sat_sum(sum_ab, -round_div(dx * dy * 65536, l2));
        sum_ac = sat_sum(sum_ac, -round_div(dy * dy * px - dx * dy * py, l2));
        sum_bc = sat_sum(sum_bc, round_div(dx * dy * px - dx * dx * py, l2));
      end
    end
    if (!r.last_line) return 1'b0;
    den = wide_mul(sum_ab, sum_ab) - wide_mul(sum_aa, sum_bb);
    pt.point_z = first_z;
    pt.singular = bad_dir_seen || den == '0;
    pt.point_x = '0;
    pt.point_y = '0;
    if (!pt.singular) begin
      nx = wide_mul(sum_bb, sum_ac) - wide_mul(sum_ab, sum_bc);
      ny = wide_mul(sum_aa, sum_bc) - wide_mul(sum_ab, sum_ac);
      pt.point_x = coord_div(nx, den);
      pt.point_y = coord_div(ny, den);
    end
    clear_level();
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    res_t pt, want;
    if (rst_ni) begin
      if (done_o) begin
        if (point_q.size() == 0) begin
          $error("result with none expected: %p", res_o);
          errors++;
        end else begin
          want = point_q.pop_front();
          if (res_o.point_x !== want.point_x) begin
            $error("point_x exp %h got %h", want.point_x, res_o.point_x);
            errors++;
          end
          if (res_o.point_y !== want.point_y) begin
            $error("point_y exp %h got %h", want.point_y, res_o.point_y);
            errors++;
          end
          if (res_o.point_z !== want.point_z) begin
            $error("point_z exp %h got %h", want.point_z, res_o.point_z);
            errors++;
          end
          if (res_o.singular !== want.singular) begin
            $error("singular exp %b got %b", want.singular, res_o.singular);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) begin
        if (add_line(req_i, pt)) point_q.push_back(typed_q ? typed_res_q : pt);
      end
    end
  end

  int burst_left;

  task automatic send(req_t r, bit typed, res_t res);
    start_i <= 1'b1;
    req_i <= r;
    typed_q <= typed;
    typed_res_q <= res;
    do @(posedge clk_i); while (busy_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  function automatic req_t mk(int dx, int dy, int dz, int px, int py, int pz, bit last);
    req_t r;
    r.dir_x = 16'(dx); r.dir_y = 16'(dy); r.dir_z = 16'(dz);
    r.pos_x = px; r.pos_y = py; r.pos_z = pz;
    r.last_line = last;
    return r;
  endfunction

  function automatic res_t pt(int x, int y, int z, bit s);
    res_t p;
    p.point_x = x; p.point_y = y; p.point_z = z; p.singular = s;
    return p;
  endfunction

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      2, 3: return 16'($signed($urandom_range(0, 20)) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1, 2: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      default: return $urandom;
    endcase
  endfunction

  row_t dir_rows[$];

  initial begin
    res_t none;
    req_t r;
    int n_lines, sent;
    logic [15:0] dx, dy, dz;
    bit same_dir;
    none = '0;
    errors = 0;
    burst_left = 0;
    clear_level();
    start_i = 1'b0;
    req_i = '0;
    typed_q = 1'b0;
    typed_res_q = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows = '{
      '{mk(0, 0, 0, 5, 6, 32'h1234_5678, 1), 1, pt(0, 0, 32'h1234_5678, 1)},
      '{mk(1, 0, 0, 0, 32'h0002_0000, 32'hFEDC_BA98, 0), 0, none},
      '{mk(1, 0, 0, 0, -32'sh0003_0000, 7, 1), 1, pt(0, 0, 32'hFEDC_BA98, 1)},
      '{mk(1, 0, 0, 32'h0100_0000, -32'sh0001_4000, 32'h0000_1000, 0), 0, none},
      '{mk(0, 1, 0, 32'h0003_8000, 32'h0777_0000, 32'h5555_0000, 1), 1,
        pt(32'h0003_8000, -32'sh0001_4000, 32'h0000_1000, 0)},
      '{mk(-32768, 32767, -32768, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0), 0, none},
      '{mk(32767, -32768, 32767, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0), 0, none},
      '{mk(32767, 32767, 0, 32'h8000_0000, 32'h8000_0000, 1, 1), 0, none},
      '{mk(3, 4, 0, 32'h0001_0000, 32'h0002_0000, 32'h8000_0000, 0), 0, none},
      '{mk(0, 0, 0, 9, 9, 9, 1), 1, pt(0, 0, 32'h8000_0000, 1)},
      '{mk(5, -7, 2, 32'h0004_0000, 32'h0000_8000, 32'h0000_0003, 1), 0, none},
      '{mk(1000, 1, 0, 0, 32'h7FFF_0000, 2, 0), 0, none},
      '{mk(1000, 2, 0, 0, -32'sh7FFF_0000, 3, 1), 0, none},
      '{mk(-1, -1, -1, -1, -1, -1, 0), 0, none},
      '{mk(-1, 1, 0, 32'h0000_FFFF, 32'hFFFF_0000, -1, 1), 0, none}
    };
    foreach (dir_rows[i]) send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    start_i <= 1'b0;
    while (point_q.size() != 0) @(posedge clk_i);

    sent = 0;
    while (sent < NumRandom) begin
      case ($urandom_range(0, 19))
        0: n_lines = 1;
        1: n_lines = $urandom_range(MaxLines - 1, MaxLines + 6);
        default: n_lines = $urandom_range(2, 6);
      endcase
      same_dir = ($urandom_range(0, 9) == 0);
      dx = rand_dir(); dy = rand_dir(); dz = rand_dir();
      for (int k = 0; k < n_lines; k++) begin
        if (!same_dir) begin
          dx = rand_dir(); dy = rand_dir(); dz = rand_dir();
        end
        r = mk(0, 0, 0, 0, 0, 0, 0);
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        r.pos_x = rand_pos(); r.pos_y = rand_pos(); r.pos_z = rand_pos();
        r.last_line = (k == n_lines - 1);
        send(r, 1'b0, none);
        sent++;
      end
      if (sent > NumRandom / 2 && sent <= NumRandom / 2 + 8) begin
        start_i <= 1'b0;
        while (point_q.size() != 0) @(posedge clk_i);
      end
    end

    start_i <= 1'b0;
    while (point_q.size() != 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
    if (errors == 0 && point_q.size() == 0) begin
      $display("PASS least_squares_line_intersection");
    end else begin
      $display("FAIL least_squares_line_intersection");
    end
    $finish;
  end

endmodule
